### rtl/core/bllsc_pkg.sv
`default_nettype none

package bllsc_pkg;

    // Defaults for the top-level parameters.
    localparam int ALPHABET_SIZE_DEF = 256;
    localparam int COUNT_BITS_DEF    = 24;
    localparam int SCORE_BITS_DEF    = 32;
    localparam int LOG_FRAC_BITS_DEF = 10;

    // Log unit constants: log2 carries 28 fraction bits and ln(2) is held in Q0.30.
    localparam int          LOG2_FRAC   = 28;
    localparam int          LOG2_INT    = 5;
    localparam int          LN_INT_BITS = 5;
    localparam logic [29:0] LN2_Q30     = 30'd744261118;

    // Depth of the queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    // Request commands.
    localparam logic CMD_TRAIN = 1'b0;
    localparam logic CMD_SCORE = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] data_byte;
        logic       last;
    } t_in;

    typedef struct packed {
        logic [31:0] score;
        logic        saturated;
    } t_out;

    typedef enum logic [1:0] {
        JOB_NONE,
        JOB_TRAIN,
        JOB_SCORE
    } t_job_kind;

    // One classified request on its way from the front to the back.
    typedef struct packed {
        t_job_kind  kind;
        logic [7:0] prev_byte;
        logic [7:0] cur_byte;
        logic       last;
        logic       emit;
    } t_job;

    typedef enum logic [2:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_LOG,
        BK_FINISH
    } t_back_state;

    typedef enum logic [2:0] {
        LN_IDLE,
        LN_NORM,
        LN_SQUARE,
        LN_MUL_HI,
        LN_MUL_LO,
        LN_ROUND,
        LN_DONE
    } t_ln_state;

endpackage

`default_nettype wire

### rtl/core/bigram_log_likelihood_scorer_core.sv
// A request that is taken is written into the queue, from which the back end pops it;
// the back end handles one job at a time while the front keeps filling the queue.
// A scored pair with a nonzero count holds the back end for the 28 sequential squarings
// of the log unit; training pairs and requests that form no pair need no log step.
// Reset: control state clears at once, then a pass zeroes all ALPHABET_SIZE**2 entries
// (65536 by default) of the pair-count memory, one a cycle, with o_req_ready held low.
`default_nettype none

module bigram_log_likelihood_scorer_core #(
    parameter int ALPHABET_SIZE = bllsc_pkg::ALPHABET_SIZE_DEF,
    parameter int COUNT_BITS    = bllsc_pkg::COUNT_BITS_DEF,
    parameter int SCORE_BITS    = bllsc_pkg::SCORE_BITS_DEF,
    parameter int LOG_FRAC_BITS = bllsc_pkg::LOG_FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_ready,
    input  wire bllsc_pkg::t_in   i_req,
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_ready,
    output bllsc_pkg::t_out       o_rsp
);
    import bllsc_pkg::*;

    // The front end tracks the previous byte of the current run and turns every request
    // into a job: a pair to train, a pair to score, or no pair at all. The job also keeps
    // the run boundary and whether a result is due, so the back end never looks at the
    // request stream itself.
    logic clear_busy;
    logic push;
    t_job push_job;
    logic queue_full;
    logic queue_empty;
    logic pop;
    t_job head_job;

    bllsc_front #(
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_req_valid),
        .o_req_ready  (o_req_ready),
        .i_req        (i_req),
        .i_clear_busy (clear_busy),
        .i_queue_full (queue_full),
        .o_push       (push),
        .o_job        (push_job)
    );

    // A short queue decouples the two halves: the front keeps taking requests while the
    // back end is busy with a log computation or waits on a stalled result.
    bllsc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_job),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_head  (head_job)
    );

    // The back end owns the pair-count memory and the running score. It handles one job at
    // a time with a read-modify-write of the memory, so a read always sees the write of the
    // job before it. Results leave through a registered output stage, which lets the back
    // end continue with later jobs as long as it does not need to emit a second result.
    bllsc_back #(
        .ALPHABET_SIZE (ALPHABET_SIZE),
        .COUNT_BITS    (COUNT_BITS),
        .SCORE_BITS    (SCORE_BITS),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (!queue_empty),
        .i_job        (head_job),
        .o_job_pop    (pop),
        .o_clear_busy (clear_busy),
        .o_rsp_valid  (o_rsp_valid),
        .i_rsp_ready  (i_rsp_ready),
        .o_rsp        (o_rsp)
    );

endmodule

`default_nettype wire

### rtl/core/bllsc_front.sv
`default_nettype none

module bllsc_front #(
    parameter int ALPHABET_SIZE = bllsc_pkg::ALPHABET_SIZE_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_req_valid,
    output logic                  o_req_ready,
    input  wire bllsc_pkg::t_in   i_req,
    input  wire logic             i_clear_busy,
    input  wire logic             i_queue_full,
    output logic                  o_push,
    output bllsc_pkg::t_job       o_job
);
    import bllsc_pkg::*;

    logic [7:0] r_prev_byte;
    logic [7:0] n_prev_byte;
    logic       r_have_prev;
    logic       n_have_prev;
    logic       prev_in_range;
    logic       cur_in_range;
    logic       pair_ok;

    assign o_req_ready = !i_queue_full && !i_clear_busy;
    assign o_push      = i_req_valid && o_req_ready;

    // A pair exists only inside a run and only when both symbols are in the alphabet.
    assign prev_in_range = {1'b0, r_prev_byte} < 9'(ALPHABET_SIZE);
    assign cur_in_range  = {1'b0, i_req.data_byte} < 9'(ALPHABET_SIZE);
    assign pair_ok       = r_have_prev && prev_in_range && cur_in_range;

    always_comb begin
        o_job.prev_byte = r_prev_byte;
        o_job.cur_byte  = i_req.data_byte;
        o_job.last      = i_req.last;
        o_job.emit      = i_req.last && (i_req.cmd == CMD_SCORE);
        if (!pair_ok) begin
            o_job.kind = JOB_NONE;
        end else if (i_req.cmd == CMD_SCORE) begin
            o_job.kind = JOB_SCORE;
        end else begin
            o_job.kind = JOB_TRAIN;
        end

        n_prev_byte = r_prev_byte;
        n_have_prev = r_have_prev;
        if (o_push) begin
            if (i_req.last) begin
                n_prev_byte = 8'd0;
                n_have_prev = 1'b0;
            end else begin
                n_prev_byte = i_req.data_byte;
                n_have_prev = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_byte <= 8'd0;
            r_have_prev <= 1'b0;
        end else begin
            r_prev_byte <= n_prev_byte;
            r_have_prev <= n_have_prev;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bllsc_fifo.sv
`default_nettype none

module bllsc_fifo #(
    parameter int DEPTH = bllsc_pkg::QUEUE_DEPTH
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire bllsc_pkg::t_job  i_data,
    output logic                  o_full,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output bllsc_pkg::t_job       o_head
);
    import bllsc_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_job             r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_slots[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### rtl/core/bllsc_ln.sv
`default_nettype none

module bllsc_ln #(
    parameter int COUNT_BITS    = bllsc_pkg::COUNT_BITS_DEF,
    parameter int LOG_FRAC_BITS = bllsc_pkg::LOG_FRAC_BITS_DEF
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_rst_n,
    input  wire logic                                         i_start,
    input  wire logic [COUNT_BITS-1:0]                        i_count,
    output logic                                              o_done,
    output logic [LOG_FRAC_BITS+bllsc_pkg::LN_INT_BITS-1:0]   o_ln
);
    import bllsc_pkg::*;

    localparam int LN_W       = LOG_FRAC_BITS + LN_INT_BITS;
    localparam int L2_W       = LOG2_INT + LOG2_FRAC;
    localparam int L2_LO      = L2_W / 2;
    localparam int HI_W       = L2_W - L2_LO + 30;
    localparam int LO_W       = L2_LO + 30;
    localparam int SH         = 30 + LOG2_FRAC - LOG_FRAC_BITS;
    localparam int NORM_STEPS = 5;
    localparam logic [63:0] ROUND_HALF = 64'd1 << (SH - 1);

    t_ln_state            r_state;
    t_ln_state            n_state;
    logic [31:0]          r_m;
    logic [31:0]          n_m;
    logic [4:0]           r_exp;
    logic [4:0]           n_exp;
    logic [4:0]           r_cnt;
    logic [4:0]           n_cnt;
    logic [LOG2_FRAC-1:0] r_frac;
    logic [LOG2_FRAC-1:0] n_frac;
    logic [HI_W-1:0]      r_prod_hi;
    logic [HI_W-1:0]      n_prod_hi;
    logic [LO_W-1:0]      r_prod_lo;
    logic [LO_W-1:0]      n_prod_lo;
    logic [LN_W-1:0]      r_ln;
    logic [LN_W-1:0]      n_ln;

    logic [5:0]           shift_amt;
    logic [31:0]          top_mask;
    logic [63:0]          square;
    logic [32:0]          scaled;
    logic [L2_W-1:0]      log2_val;
    logic [63:0]          total;

    assign o_done   = (r_state == LN_DONE);
    assign o_ln     = r_ln;
    assign log2_val = {r_exp, r_frac};

    always_comb begin
        n_state   = r_state;
        n_m       = r_m;
        n_exp     = r_exp;
        n_cnt     = r_cnt;
        n_frac    = r_frac;
        n_prod_hi = r_prod_hi;
        n_prod_lo = r_prod_lo;
        n_ln      = r_ln;

        shift_amt = 6'd16 >> r_cnt[2:0];
        top_mask  = ~(32'hFFFF_FFFF >> shift_amt);
        square    = 64'(r_m) * 64'(r_m);
        scaled    = 33'(square >> 31);
        total     = (64'(r_prod_hi) << L2_LO) + 64'(r_prod_lo) + ROUND_HALF;

        case (r_state)
            LN_IDLE: begin
                if (i_start) begin
                    n_m     = 32'(i_count);
                    n_exp   = 5'd31;
                    n_cnt   = '0;
                    n_frac  = '0;
                    n_state = LN_NORM;
                end
            end
            // Binary search for the leading one: shifts of 16, 8, 4, 2 and 1.
            LN_NORM: begin
                if ((r_m & top_mask) == 32'd0) begin
                    n_m   = r_m << shift_amt;
                    n_exp = r_exp - 5'(shift_amt);
                end
                if (r_cnt == 5'(NORM_STEPS - 1)) begin
                    n_cnt   = 5'(LOG2_FRAC - 1);
                    n_state = LN_SQUARE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            // One fraction bit of log2 per squaring of the Q1.31 mantissa.
            LN_SQUARE: begin
                if (scaled[32]) begin
                    n_m    = scaled[32:1];
                    n_frac = {r_frac[LOG2_FRAC-2:0], 1'b1};
                end else begin
                    n_m    = scaled[31:0];
                    n_frac = {r_frac[LOG2_FRAC-2:0], 1'b0};
                end
                if (r_cnt == 5'd0) begin
                    n_state = LN_MUL_HI;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            LN_MUL_HI: begin
                n_prod_hi = HI_W'(log2_val[L2_W-1:L2_LO]) * HI_W'(LN2_Q30);
                n_state   = LN_MUL_LO;
            end
            LN_MUL_LO: begin
                n_prod_lo = LO_W'(log2_val[L2_LO-1:0]) * LO_W'(LN2_Q30);
                n_state   = LN_ROUND;
            end
            LN_ROUND: begin
                n_ln    = LN_W'(total >> SH);
                n_state = LN_DONE;
            end
            LN_DONE: begin
                n_state = LN_IDLE;
            end
            default: begin
                n_state = LN_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LN_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m       <= n_m;
        r_exp     <= n_exp;
        r_frac    <= n_frac;
        r_prod_hi <= n_prod_hi;
        r_prod_lo <= n_prod_lo;
        r_ln      <= n_ln;
    end

endmodule

`default_nettype wire

### rtl/core/bllsc_back.sv
`default_nettype none

module bllsc_back #(
    parameter int ALPHABET_SIZE = bllsc_pkg::ALPHABET_SIZE_DEF,
    parameter int COUNT_BITS    = bllsc_pkg::COUNT_BITS_DEF,
    parameter int SCORE_BITS    = bllsc_pkg::SCORE_BITS_DEF,
    parameter int LOG_FRAC_BITS = bllsc_pkg::LOG_FRAC_BITS_DEF
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_job_valid,
    input  wire bllsc_pkg::t_job  i_job,
    output logic                  o_job_pop,
    output logic                  o_clear_busy,
    output logic                  o_rsp_valid,
    input  wire logic             i_rsp_ready,
    output bllsc_pkg::t_out       o_rsp
);
    import bllsc_pkg::*;

    localparam int DEPTH  = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int LN_W   = LOG_FRAC_BITS + LN_INT_BITS;
    localparam int SUM_W  = ((SCORE_BITS > LN_W) ? SCORE_BITS : LN_W) + 1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [SUM_W-1:0] SCORE_MAX = SUM_W'((64'd1 << SCORE_BITS) - 64'd1);

    logic [COUNT_BITS-1:0] r_table [DEPTH];
    logic [COUNT_BITS-1:0] r_rd_data;

    t_back_state           r_state;
    t_back_state           n_state;
    logic [ADDR_W-1:0]     r_clr_addr;
    logic [ADDR_W-1:0]     n_clr_addr;
    t_job                  r_job;
    t_job                  n_job;
    logic [SCORE_BITS-1:0] r_sum;
    logic [SCORE_BITS-1:0] n_sum;
    logic                  r_ovf;
    logic                  n_ovf;
    logic                  r_rsp_valid;
    logic                  n_rsp_valid;
    t_out                  r_rsp;
    t_out                  n_rsp;

    logic [ADDR_W-1:0]        job_addr;
    logic                     mem_we;
    logic [ADDR_W-1:0]        mem_waddr;
    logic [COUNT_BITS-1:0]    mem_wdata;
    logic                     ln_start;
    logic                     ln_done;
    logic [LN_W-1:0]          ln_val;
    logic [SUM_W-1:0]         sum_wide;
    logic [SCORE_BITS+31:0]   sum_ext;
    logic                     out_free;

    assign job_addr     = ADDR_W'(32'(r_job.prev_byte) * ALPHABET_SIZE + 32'(r_job.cur_byte));
    assign ln_start     = (r_state == BK_CHECK) && (r_job.kind == JOB_SCORE)
                          && (r_rd_data != '0);
    assign sum_wide     = SUM_W'(r_sum) + SUM_W'(ln_val);
    assign sum_ext      = {32'd0, r_sum};
    assign out_free     = !r_rsp_valid || i_rsp_ready;
    assign o_clear_busy = (r_state == BK_CLEAR);
    assign o_rsp_valid  = r_rsp_valid;
    assign o_rsp        = r_rsp;

    bllsc_ln #(
        .COUNT_BITS    (COUNT_BITS),
        .LOG_FRAC_BITS (LOG_FRAC_BITS)
    ) u_ln (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ln_start),
        .i_count (r_rd_data),
        .o_done  (ln_done),
        .o_ln    (ln_val)
    );

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_job       = r_job;
        n_sum       = r_sum;
        n_ovf       = r_ovf;
        n_rsp       = r_rsp;
        n_rsp_valid = r_rsp_valid;
        o_job_pop   = 1'b0;
        mem_we      = 1'b0;
        mem_waddr   = job_addr;
        mem_wdata   = r_rd_data + COUNT_BITS'(1);

        if (i_rsp_ready) begin
            n_rsp_valid = 1'b0;
        end

        case (r_state)
            BK_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = BK_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            BK_IDLE: begin
                if (i_job_valid) begin
                    o_job_pop = 1'b1;
                    n_job     = i_job;
                    n_state   = (i_job.kind == JOB_NONE) ? BK_FINISH : BK_READ;
                end
            end
            BK_READ: begin
                n_state = BK_CHECK;
            end
            BK_CHECK: begin
                if (r_job.kind == JOB_TRAIN) begin
                    mem_we  = (r_rd_data != COUNT_MAX);
                    n_state = BK_FINISH;
                end else if (r_rd_data != '0) begin
                    n_state = BK_LOG;
                end else begin
                    n_state = BK_FINISH;
                end
            end
            BK_LOG: begin
                if (ln_done) begin
                    if (sum_wide > SCORE_MAX) begin
                        n_sum = SCORE_BITS'(SCORE_MAX);
                        n_ovf = 1'b1;
                    end else begin
                        n_sum = SCORE_BITS'(sum_wide);
                    end
                    n_state = BK_FINISH;
                end
            end
            BK_FINISH: begin
                if (!r_job.last) begin
                    n_state = BK_IDLE;
                end else if (!r_job.emit) begin
                    n_sum   = '0;
                    n_ovf   = 1'b0;
                    n_state = BK_IDLE;
                end else if (out_free) begin
                    n_rsp.score     = sum_ext[31:0];
                    n_rsp.saturated = r_ovf;
                    n_rsp_valid     = 1'b1;
                    n_sum           = '0;
                    n_ovf           = 1'b0;
                    n_state         = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_CLEAR;
            r_clr_addr  <= '0;
            r_sum       <= '0;
            r_ovf       <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_sum       <= n_sum;
            r_ovf       <= n_ovf;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_job <= n_job;
        r_rsp <= n_rsp;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_table[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= r_table[job_addr];
    end

endmodule

`default_nettype wire

### rtl/core/bllsc_checker.sv
`default_nettype none

module bllsc_checker #(
    parameter int SCORE_BITS = bllsc_pkg::SCORE_BITS_DEF
) (
    input wire logic             i_clk,
    input wire logic             i_rst_n,
    input wire logic             i_req_valid,
    input wire logic             o_req_ready,
    input wire bllsc_pkg::t_in   i_req,
    input wire logic             o_rsp_valid,
    input wire logic             i_rsp_ready,
    input wire bllsc_pkg::t_out  o_rsp
);
    import bllsc_pkg::*;

    localparam logic [63:0] SAT_FULL  = (64'd1 << SCORE_BITS) - 64'd1;
    localparam logic [31:0] SAT_SCORE = SAT_FULL[31:0];

    // A waiting result is held until it is taken.
    a_rsp_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> o_rsp_valid)
        else $error("result dropped before it was taken");

    a_rsp_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && !i_rsp_ready |=> $stable(o_rsp))
        else $error("stalled result changed");

    // The memory clearing pass starts right after reset, so no request may be taken then.
    a_ready_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_req_ready && !o_rsp_valid)
        else $error("block ready during the clearing pass");

    // A saturated score sits at its maximum value.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && o_rsp.saturated |-> o_rsp.score == SAT_SCORE)
        else $error("saturated result without the maximum score");

    // A result may not rise straight out of reset.
    a_rsp_needs_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp_valid) |-> !$past(!i_rst_n))
        else $error("result right after reset");

endmodule

bind bigram_log_likelihood_scorer_core bllsc_checker #(
    .SCORE_BITS (SCORE_BITS)
) u_bllsc_checker (.*);

`default_nettype wire
